FILE: src/sng_pkg.sv
`timescale 1ns / 1ps

package sng_pkg;

  // default datapath widths
  localparam int SNG_SAMPLE_BITS = 16;
  localparam int SNG_COEF_BITS   = 16;

  // depth of the queue between classifier and envelope back end
  localparam int SNG_QUEUE_DEPTH = 2;

  // register reset values, cut down to the register width at use
  localparam logic [31:0] THRESHOLD_RESET = 32'd655;
  localparam logic [31:0] ATTACK_RESET    = 32'd64183;
  localparam logic [31:0] RELEASE_RESET   = 32'd65519;

  // register map
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_ATTACK    = 2'd1,
    REG_RELEASE   = 2'd2
  } sng_reg_e;

endpackage

FILE: src/sng_if.sv
`timescale 1ns / 1ps

// sample pair channel into the gate
interface sng_in_if
  import sng_pkg::*;
#(
  parameter int SAMPLE_BITS = SNG_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          last_in;

  modport source (output valid, output left_in, output right_in, output last_in,
                  input ready);
  modport sink (input valid, input left_in, input right_in, input last_in,
                output ready);
endinterface

// gated sample pair channel out of the gate
interface sng_out_if
  import sng_pkg::*;
#(
  parameter int SAMPLE_BITS = SNG_SAMPLE_BITS,
  parameter int COEF_BITS   = SNG_COEF_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic        [COEF_BITS:0]     gain_out;
  logic                          last_out;

  modport source (output valid, output left_out, output right_out, output gain_out,
                  output last_out, input ready);
  modport sink (input valid, input left_out, input right_out, input gain_out,
                input last_out, output ready);
endinterface

FILE: src/stereo_noise_gate_top.sv
`timescale 1ns / 1ps
// stereo noise gate with a one-pole gain envelope
// path: an accepted word is written into the queue, then the envelope register, then the output register
// throughput: one sample pair per cycle while the output is not stalled, bounded by the
//   envelope update loop (one gap times coefficient multiply feeding the gain register)
// reset: gain envelope at 1.0, registers at their defaults, queue and stages empty

module stereo_noise_gate_top
  import sng_pkg::*;
#(
  parameter int SAMPLE_BITS = SNG_SAMPLE_BITS,
  parameter int COEF_BITS   = SNG_COEF_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sng_in_if.sink               in_i,
  sng_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [((SAMPLE_BITS-1 > COEF_BITS) ? SAMPLE_BITS-1 : COEF_BITS)-1:0] cfg_data_i
);

  localparam int ITEM_W = 2 * SAMPLE_BITS + 2;

  logic [SAMPLE_BITS-2:0] threshold_q;
  logic [COEF_BITS-1:0]   attack_coef_q;
  logic [COEF_BITS-1:0]   release_coef_q;
  logic                   push_valid;
  logic [ITEM_W-1:0]      push_data;
  logic                   push_ready;
  logic                   pop_valid;
  logic [ITEM_W-1:0]      pop_data;
  logic                   pop_ready;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= THRESHOLD_RESET[SAMPLE_BITS-2:0];
      attack_coef_q  <= ATTACK_RESET[COEF_BITS-1:0];
      release_coef_q <= RELEASE_RESET[COEF_BITS-1:0];
    end else if (cfg_we_i) begin
      case (sng_reg_e'(cfg_idx_i))
        REG_THRESHOLD: threshold_q    <= cfg_data_i[SAMPLE_BITS-2:0];
        REG_ATTACK:    attack_coef_q  <= cfg_data_i[COEF_BITS-1:0];
        REG_RELEASE:   release_coef_q <= cfg_data_i[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // classifier
  sng_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ITEM_W      (ITEM_W)
  ) u_front (
    .in_i         (in_i),
    .threshold_i  (threshold_q),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  // decoupling queue
  sng_queue #(
    .ITEM_W (ITEM_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  // envelope and gain back end
  sng_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .ITEM_W      (ITEM_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_data_i     (pop_data),
    .pop_ready_o    (pop_ready),
    .attack_coef_i  (attack_coef_q),
    .release_coef_i (release_coef_q),
    .out_o          (out_o)
  );

endmodule

FILE: src/sng_front.sv
`timescale 1ns / 1ps

module sng_front
  import sng_pkg::*;
#(
  parameter int SAMPLE_BITS = SNG_SAMPLE_BITS,
  parameter int ITEM_W      = 2 * SNG_SAMPLE_BITS + 2
) (
  sng_in_if.sink                  in_i,
  input  logic [SAMPLE_BITS-2:0]  threshold_i,
  output logic                    push_valid_o,
  output logic [ITEM_W-1:0]       push_data_o,
  input  logic                    push_ready_i
);

  logic signed [SAMPLE_BITS:0] left_x;
  logic signed [SAMPLE_BITS:0] right_x;
  logic        [SAMPLE_BITS-1:0] left_mag;
  logic        [SAMPLE_BITS-1:0] right_mag;
  logic        [SAMPLE_BITS-1:0] peak;
  logic                          gate_open;

  // magnitudes; full-scale negative gives 2**(SAMPLE_BITS-1), above any threshold
  assign left_x    = {in_i.left_in[SAMPLE_BITS-1], in_i.left_in};
  assign right_x   = {in_i.right_in[SAMPLE_BITS-1], in_i.right_in};
  assign left_mag  = left_x[SAMPLE_BITS]  ? SAMPLE_BITS'(-left_x)  : SAMPLE_BITS'(left_x);
  assign right_mag = right_x[SAMPLE_BITS] ? SAMPLE_BITS'(-right_x) : SAMPLE_BITS'(right_x);

  // strict compare of the larger magnitude against the threshold
  assign peak      = (left_mag > right_mag) ? left_mag : right_mag;
  assign gate_open = peak > {1'b0, threshold_i};

  // queue word: last, gate decision, right, left
  assign push_data_o  = {in_i.last_in, gate_open, in_i.right_in, in_i.left_in};
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

FILE: src/sng_queue.sv
`timescale 1ns / 1ps

module sng_queue
  import sng_pkg::*;
#(
  parameter int ITEM_W = 2 * SNG_SAMPLE_BITS + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  logic [ITEM_W-1:0] push_data_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output logic [ITEM_W-1:0] pop_data_o,
  input  logic              pop_ready_i
);

  localparam int PTR_W = (SNG_QUEUE_DEPTH > 1) ? $clog2(SNG_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(SNG_QUEUE_DEPTH + 1);

  logic [ITEM_W-1:0] mem_q [SNG_QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push;
  logic              pop;

  assign push_ready_o = count_q != CNT_W'(SNG_QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill count update with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(SNG_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(SNG_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/sng_back.sv
`timescale 1ns / 1ps

module sng_back
  import sng_pkg::*;
#(
  parameter int SAMPLE_BITS = SNG_SAMPLE_BITS,
  parameter int COEF_BITS   = SNG_COEF_BITS,
  parameter int ITEM_W      = 2 * SNG_SAMPLE_BITS + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  input  logic [ITEM_W-1:0]    pop_data_i,
  output logic                 pop_ready_o,
  input  logic [COEF_BITS-1:0] attack_coef_i,
  input  logic [COEF_BITS-1:0] release_coef_i,
  sng_out_if.source            out_o
);

  localparam int GW = COEF_BITS + 1;
  localparam logic [GW-1:0] GAIN_ONE = {1'b1, {COEF_BITS{1'b0}}};
  localparam int PW = SAMPLE_BITS + COEF_BITS + 2;

  // unpacked queue word
  logic signed [SAMPLE_BITS-1:0] q_left;
  logic signed [SAMPLE_BITS-1:0] q_right;
  logic                          q_open;
  logic                          q_last;

  // envelope stage
  logic                          rising;
  logic [GW-1:0]                 gap;
  logic [COEF_BITS-1:0]          coef;
  logic [GW+COEF_BITS-1:0]       gap_prod;
  logic [GW-1:0]                 gap_step;
  logic [GW-1:0]                 env_d, env_q;
  logic                          env_valid_q;
  logic signed [SAMPLE_BITS-1:0] env_left_q;
  logic signed [SAMPLE_BITS-1:0] env_right_q;
  logic                          env_last_q;

  // gain stage
  logic signed [PW-1:0]          left_prod;
  logic signed [PW-1:0]          right_prod;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_left_q;
  logic signed [SAMPLE_BITS-1:0] out_right_q;
  logic [GW-1:0]                 out_gain_q;
  logic                          out_last_q;
  logic                          out_free;
  logic                          env_free;
  logic                          env_load;

  assign q_left  = pop_data_i[SAMPLE_BITS-1:0];
  assign q_right = pop_data_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign q_open  = pop_data_i[2*SAMPLE_BITS];
  assign q_last  = pop_data_i[2*SAMPLE_BITS+1];

  // stage flow control
  assign out_free    = !out_valid_q || out_o.ready;
  assign env_free    = !env_valid_q || out_free;
  assign pop_ready_o = env_free;
  assign env_load    = pop_valid_i && env_free;

  // one pole step: shrink the distance to the target, rounded toward it
  assign rising   = q_open && (env_q < GAIN_ONE);
  assign coef     = rising ? attack_coef_i : release_coef_i;
  assign gap      = rising ? (GAIN_ONE - env_q) : (q_open ? (env_q - GAIN_ONE) : env_q);
  assign gap_prod = gap * coef;
  assign gap_step = gap_prod[GW+COEF_BITS-1:COEF_BITS];

  always_comb begin
    if (rising) begin
      env_d = GAIN_ONE - gap_step;
    end else if (q_open) begin
      env_d = GAIN_ONE + gap_step;
    end else begin
      env_d = gap_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q       <= GAIN_ONE;
      env_valid_q <= 1'b0;
    end else if (env_free) begin
      env_valid_q <= pop_valid_i;
      if (pop_valid_i) begin
        env_q <= env_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (env_load) begin
      env_left_q  <= q_left;
      env_right_q <= q_right;
      env_last_q  <= q_last;
    end
  end

  // gain applied to both channels, floored shift back to sample scale
  assign left_prod  = env_left_q * $signed({1'b0, env_q});
  assign right_prod = env_right_q * $signed({1'b0, env_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= env_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && env_valid_q) begin
      out_left_q  <= left_prod[COEF_BITS+SAMPLE_BITS-1:COEF_BITS];
      out_right_q <= right_prod[COEF_BITS+SAMPLE_BITS-1:COEF_BITS];
      out_gain_q  <= env_q;
      out_last_q  <= env_last_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = out_left_q;
  assign out_o.right_out = out_right_q;
  assign out_o.gain_out  = out_gain_q;
  assign out_o.last_out  = out_last_q;

endmodule

FILE: src/sng_checker.sv
`timescale 1ns / 1ps

module sng_checker
  import sng_pkg::*;
#(
  parameter int SAMPLE_BITS = SNG_SAMPLE_BITS,
  parameter int COEF_BITS   = SNG_COEF_BITS
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] left_out_i,
  input logic [SAMPLE_BITS-1:0] right_out_i,
  input logic [COEF_BITS:0]     gain_out_i,
  input logic                   last_out_i
);

  localparam logic [COEF_BITS:0] GAIN_ONE = {1'b1, {COEF_BITS{1'b0}}};

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(left_out_i) &&
      $stable(right_out_i) && $stable(gain_out_i) && $stable(last_out_i))
    else $error("output word changed while stalled");

  // envelope never goes above unity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> gain_out_i <= GAIN_ONE)
    else $error("gain above unity");

  // a fully closed gate silences both channels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && gain_out_i == '0 |-> left_out_i == '0 && right_out_i == '0)
    else $error("nonzero sample at zero gain");

endmodule

bind stereo_noise_gate_top sng_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .COEF_BITS   (COEF_BITS)
) u_sng_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .left_out_i  (out_o.left_out),
  .right_out_i (out_o.right_out),
  .gain_out_i  (out_o.gain_out),
  .last_out_i  (out_o.last_out)
);
